>>> hw/rtl/bpd_pkg.sv
// ----------------------------------------------------------------------------
// bpd_pkg
// Shared types, constants and helpers for the bitmap page dispenser.
// ----------------------------------------------------------------------------
`default_nettype none

package bpd_pkg;

  localparam int MAX_SECTORS      = 64;
  localparam int PAGES_PER_SECTOR = 64;
  localparam int IDX_W            = 6;
  localparam int BIT_W            = 6;
  localparam int BMP_W            = PAGES_PER_SECTOR;
  localparam int VOL_W            = 15;
  localparam int SID_W            = 25;
  localparam int TAG_W            = 8;
  localparam int PID_W            = 31;
  localparam int CNT_W            = 7;
  localparam int WRK_W            = 9;
  localparam int META_W           = VOL_W + SID_W + TAG_W;
  localparam int MODC_W           = 3;

  typedef enum logic [2:0] {
    OP_LOAD       = 3'd0,
    OP_POP_SECTOR = 3'd1,
    OP_POP_ANY    = 3'd2,
    OP_QUERY      = 3'd3,
    OP_ENTER      = 3'd4,
    OP_LEAVE      = 3'd5,
    OP_NO_MORE    = 3'd6,
    OP_RESTART    = 3'd7
  } op_t;

  typedef struct packed {
    logic load_item;
    logic mod_start;
    logic mod_step;
    logic pick;
    logic commit;
  } bpd_cmd_t;

  typedef struct packed {
    logic mod_needed;
    logic mod_last;
    logic out_free;
  } bpd_sts_t;

  // priority encoder: position of the lowest set bit, zero for an empty word
  function automatic logic [BIT_W-1:0] lowest_set(input logic [BMP_W-1:0] v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = BMP_W - 1; i >= 0; i--) begin
      if (v[i]) pos = BIT_W'(i);
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bitmap_page_dispenser_unit.sv
// ----------------------------------------------------------------------------
// bitmap_page_dispenser_unit
// Pool of pending pages held as per-sector bitmaps, popped by sector or
// round-robin across the entries in use.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_stall  | opcode sector_index pending_bits volume_id
//           |                      | sector_id file_tag
//  out      | out_valid / out_stall| found slot_used page_volume page_id
//           |                      | file_tag_out pages_left end_of_work
//  cfg      | cfg_we               | cfg_wdata (sector_count)
//
//  One transaction at a time: after acceptance the entry is picked and read,
//  then the commit registers the result, and only after the commit does the
//  unit take the next transaction. Pop-any with entries in use first passes
//  through a reduction state that takes the cursor modulo the entry count,
//  one remainder bit each step. The commit is a single read-modify-write of the
//  bitmap RAM. Reset leaves all bitmaps empty at once through the per-entry
//  nonzero vector; no clearing pass. A stalled result holds the next commit
//  back, and no new transaction is accepted while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_dispenser_unit import bpd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [2:0]       opcode,
  input  wire logic [IDX_W-1:0] sector_index,
  input  wire logic [BMP_W-1:0] pending_bits,
  input  wire logic [VOL_W-1:0] volume_id,
  input  wire logic [SID_W-1:0] sector_id,
  input  wire logic [TAG_W-1:0] file_tag,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  found,
  output logic      [IDX_W-1:0] slot_used,
  output logic      [VOL_W-1:0] page_volume,
  output logic      [PID_W-1:0] page_id,
  output logic      [TAG_W-1:0] file_tag_out,
  output logic                  pages_left,
  output logic                  end_of_work
);

  bpd_cmd_t cmd;
  bpd_sts_t sts;

  bpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bpd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .opcode       (opcode),
    .sector_index (sector_index),
    .pending_bits (pending_bits),
    .volume_id    (volume_id),
    .sector_id    (sector_id),
    .file_tag     (file_tag),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .slot_used    (slot_used),
    .page_volume  (page_volume),
    .page_id      (page_id),
    .file_tag_out (file_tag_out),
    .pages_left   (pages_left),
    .end_of_work  (end_of_work)
  );

endmodule

`default_nettype wire

>>> hw/rtl/bpd_ram.sv
// ----------------------------------------------------------------------------
// bpd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/bpd_ctrl.sv
// ----------------------------------------------------------------------------
// bpd_ctrl
// Sequencer: accept, cursor reduction, entry pick/read, commit.
// ----------------------------------------------------------------------------
`default_nettype none

module bpd_ctrl import bpd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire bpd_sts_t sts,
  output bpd_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MOD  = 4'b0010,
    S_PICK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          cmd.mod_start = 1'b1;
          state_next    = sts.mod_needed ? S_MOD : S_PICK;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) state_next = S_PICK;
      end
      S_PICK: begin
        cmd.pick   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

`default_nettype wire

>>> hw/rtl/bpd_dp.sv
// ----------------------------------------------------------------------------
// bpd_dp
// Datapath: sector table, nonzero vector, cursor reduction, ring pick,
// bitmap read-modify-write and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpd_dp import bpd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire bpd_cmd_t         cmd,
  output bpd_sts_t              sts,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  input  wire logic [2:0]       opcode,
  input  wire logic [IDX_W-1:0] sector_index,
  input  wire logic [BMP_W-1:0] pending_bits,
  input  wire logic [VOL_W-1:0] volume_id,
  input  wire logic [SID_W-1:0] sector_id,
  input  wire logic [TAG_W-1:0] file_tag,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  found,
  output logic      [IDX_W-1:0] slot_used,
  output logic      [VOL_W-1:0] page_volume,
  output logic      [PID_W-1:0] page_id,
  output logic      [TAG_W-1:0] file_tag_out,
  output logic                  pages_left,
  output logic                  end_of_work
);

  // configuration and scan bookkeeping
  logic [CNT_W-1:0]  sector_count;
  logic [IDX_W-1:0]  steal_cursor;
  logic [WRK_W-1:0]  active_workers;
  logic              no_more_flag;
  // one bit per entry: bitmap nonzero (all clear after reset)
  logic [MAX_SECTORS-1:0] nz, nz_next;

  // captured transaction
  op_t              op_q;
  logic [IDX_W-1:0] idx_q;
  logic [BMP_W-1:0] bmp_q;
  logic [VOL_W-1:0] vol_q;
  logic [SID_W-1:0] sid_q;
  logic [TAG_W-1:0] tag_q;

  // cursor mod n, restoring remainder, one bit a cycle
  logic [IDX_W-1:0]  rem;
  logic [MODC_W-1:0] mod_cnt;
  logic [IDX_W:0]    rem_shift;

  logic [IDX_W-1:0] slot_q;
  logic             hit_q;

  logic [CNT_W-1:0]       n_use;
  logic [MAX_SECTORS:0]   use_wide;
  logic [MAX_SECTORS-1:0] in_use, avail, upper;
  logic [IDX_W-1:0]       ring_pick, target;
  logic                   target_hit;

  logic [BMP_W-1:0]  rd_bmp, cleared;
  logic [META_W-1:0] rd_meta;
  logic [BIT_W-1:0]  bit_pos;
  logic              is_load, is_pop, bmp_we;
  logic              idle_workers;

  assign n_use    = (sector_count > CNT_W'(MAX_SECTORS)) ? CNT_W'(MAX_SECTORS) : sector_count;
  assign use_wide = ({{MAX_SECTORS{1'b0}}, 1'b1} << n_use) - 1'b1;
  assign in_use   = use_wide[MAX_SECTORS-1:0];
  assign avail    = nz & in_use;

  assign rem_shift = {rem, steal_cursor[mod_cnt]};

  // ring order: first entry at or above the start point, else wrap to the bottom
  assign upper     = avail & ~(({{(MAX_SECTORS-1){1'b0}}, 1'b1} << rem) - 1'b1);
  assign ring_pick = (|upper) ? lowest_set(upper) : lowest_set(avail);

  always_comb begin
    target     = idx_q;
    target_hit = 1'b0;
    unique case (op_q)
      OP_POP_ANY: begin
        target     = ring_pick;
        target_hit = |avail;
      end
      OP_POP_SECTOR: target_hit = ({1'b0, idx_q} < n_use) && nz[idx_q];
      default: target_hit = 1'b0;
    endcase
  end

  assign sts.mod_needed = (op_t'(opcode) == OP_POP_ANY) && (n_use != '0);
  assign sts.mod_last   = (mod_cnt == '0);
  assign sts.out_free   = !out_valid || !out_stall;

  assign is_load = (op_q == OP_LOAD);
  assign is_pop  = (op_q == OP_POP_ANY) || (op_q == OP_POP_SECTOR);
  assign bmp_we  = cmd.commit && (is_load || (is_pop && hit_q));
  assign cleared = rd_bmp & (rd_bmp - 1'b1);
  assign bit_pos = lowest_set(rd_bmp);

  assign idle_workers = (active_workers == '0) || active_workers[WRK_W-1];

  always_comb begin
    nz_next = nz;
    if (cmd.commit) begin
      if (is_load)              nz_next[idx_q]  = |bmp_q;
      else if (is_pop && hit_q) nz_next[slot_q] = |cleared;
    end
  end

  bpd_ram #(.WIDTH(BMP_W), .DEPTH(MAX_SECTORS)) u_bmp_ram (
    .clk   (clk),
    .we    (bmp_we),
    .waddr (is_load ? idx_q : slot_q),
    .wdata (is_load ? bmp_q : cleared),
    .re    (cmd.pick),
    .raddr (target),
    .rdata (rd_bmp)
  );

  bpd_ram #(.WIDTH(META_W), .DEPTH(MAX_SECTORS)) u_meta_ram (
    .clk   (clk),
    .we    (cmd.commit && is_load),
    .waddr (idx_q),
    .wdata ({vol_q, sid_q, tag_q}),
    .re    (cmd.pick),
    .raddr (target),
    .rdata (rd_meta)
  );

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q  <= op_t'(opcode);
      idx_q <= sector_index;
      bmp_q <= pending_bits;
      vol_q <= volume_id;
      sid_q <= sector_id;
      tag_q <= file_tag;
    end
    if (cmd.mod_start) begin
      rem     <= '0;
      mod_cnt <= MODC_W'(IDX_W - 1);
    end else if (cmd.mod_step) begin
      rem     <= (rem_shift >= n_use) ? IDX_W'(rem_shift - n_use) : rem_shift[IDX_W-1:0];
      mod_cnt <= mod_cnt - 1'b1;
    end
    if (cmd.pick) begin
      slot_q <= target;
      hit_q  <= target_hit;
    end
    if (cmd.commit) begin
      found        <= is_pop && hit_q;
      slot_used    <= (is_pop && hit_q) ? slot_q : '0;
      page_volume  <= (is_pop && hit_q) ? rd_meta[META_W-1 -: VOL_W] : '0;
      page_id      <= (is_pop && hit_q) ? {rd_meta[TAG_W +: SID_W], bit_pos} : '0;
      file_tag_out <= (is_pop && hit_q) ? rd_meta[TAG_W-1:0] : '0;
      pages_left   <= |(nz_next & in_use);
      end_of_work  <= (op_q == OP_POP_ANY) && !hit_q && no_more_flag && idle_workers;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      sector_count   <= CNT_W'(MAX_SECTORS);
      steal_cursor   <= '0;
      active_workers <= '0;
      no_more_flag   <= 1'b0;
      nz             <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) sector_count <= cfg_wdata;
      nz <= nz_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
        unique case (op_q)
          OP_POP_ANY: steal_cursor   <= steal_cursor + 1'b1;
          OP_ENTER:   active_workers <= active_workers + 1'b1;
          OP_LEAVE:   active_workers <= active_workers - 1'b1;
          OP_NO_MORE: no_more_flag   <= 1'b1;
          OP_RESTART: begin
            steal_cursor   <= '0;
            active_workers <= '0;
            no_more_flag   <= 1'b0;
          end
          default: ;
        endcase
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bpd_checker.sv
// ----------------------------------------------------------------------------
// bpd_checker
// Port-level checks on the page dispenser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bpd_checker import bpd_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic             found,
  input wire logic [IDX_W-1:0] slot_used,
  input wire logic [VOL_W-1:0] page_volume,
  input wire logic [PID_W-1:0] page_id,
  input wire logic [TAG_W-1:0] file_tag_out,
  input wire logic             pages_left,
  input wire logic             end_of_work
);

  // a held result keeps its found flag, slot, page id, pages-left and end-of-work flags
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found) && $stable(page_id)
      && $stable(slot_used) && $stable(pages_left) && $stable(end_of_work))
    else $error("result changed while stalled");

  // a miss carries no page details
  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> slot_used == '0 && page_volume == '0
      && page_id == '0 && file_tag_out == '0)
    else $error("miss with nonzero page fields");

  a_eow_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_work |-> !found)
    else $error("end of work together with a page");

  // one transaction at a time: busy right after an acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted back to back");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bitmap_page_dispenser_unit bpd_checker u_bpd_checker (.*);

`default_nettype wire

>>> dv/bpd_checker.sv
// ----------------------------------------------------------------------------
// bpd_scoreboard
// Watches the channels of the bitmap page dispenser. Keeps its own copy of
// the sector pool, predicts the result of every accepted transaction and
// compares each returned result, field by field, with the oldest one waiting.
// ----------------------------------------------------------------------------
module bpd_scoreboard import bpd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [2:0]       opcode,
  input  logic [IDX_W-1:0] sector_index,
  input  logic [BMP_W-1:0] pending_bits,
  input  logic [VOL_W-1:0] volume_id,
  input  logic [SID_W-1:0] sector_id,
  input  logic [TAG_W-1:0] file_tag,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic             found,
  input  logic [IDX_W-1:0] slot_used,
  input  logic [VOL_W-1:0] page_volume,
  input  logic [PID_W-1:0] page_id,
  input  logic [TAG_W-1:0] file_tag_out,
  input  logic             pages_left,
  input  logic             end_of_work,
  output int               errors,
  output int               pending,
  output int               results_seen,
  output int               pages_seen,
  output int               eow_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] slot;
    logic [VOL_W-1:0] vol;
    logic [PID_W-1:0] pid;
    logic [TAG_W-1:0] tag;
    logic             left;
    logic             eow;
  } page_result_t;

  logic [BMP_W-1:0] pool_bmp [MAX_SECTORS];
  logic [VOL_W-1:0] pool_vol [MAX_SECTORS];
  logic [SID_W-1:0] pool_sid [MAX_SECTORS];
  logic [TAG_W-1:0] pool_tag [MAX_SECTORS];
  logic [IDX_W-1:0] rr_cursor;
  logic [WRK_W-1:0] worker_cnt;
  logic             drained_flag;
  logic [CNT_W-1:0] entry_limit;

  page_result_t awaited_pages [$];

  int err_cnt  = 0;
  int res_cnt  = 0;
  int page_cnt = 0;
  int eow_cnt  = 0;

  function automatic int in_use();
    return (int'(entry_limit) > MAX_SECTORS) ? MAX_SECTORS : int'(entry_limit);
  endfunction

  function automatic logic [BIT_W-1:0] first_pending(input logic [BMP_W-1:0] v);
    int b;
    b = 0;
    while (b < BMP_W - 1 && !v[b]) b++;
    return BIT_W'(b);
  endfunction

  // take the lowest pending page of one entry, if it has any
  function automatic logic claim_page(input int slot, output page_result_t hit);
    logic [BIT_W-1:0] b;
    hit = '0;
    if (pool_bmp[slot] == '0) return 1'b0;
    b = first_pending(pool_bmp[slot]);
    pool_bmp[slot][b] = 1'b0;
    hit.found = 1'b1;
    hit.slot  = IDX_W'(slot);
    hit.vol   = pool_vol[slot];
    hit.pid   = {pool_sid[slot], b};
    hit.tag   = pool_tag[slot];
    return 1'b1;
  endfunction

  function automatic page_result_t dispense_page(
    input op_t              op,
    input logic [IDX_W-1:0] idx,
    input logic [BMP_W-1:0] bmp,
    input logic [VOL_W-1:0] vol,
    input logic [SID_W-1:0] sid,
    input logic [TAG_W-1:0] tag
  );
    page_result_t res;
    page_result_t hit;
    int n;
    int start;
    logic got;
    res = '0;
    hit = '0;
    got = 1'b0;
    n   = in_use();
    case (op)
      OP_LOAD: begin
        pool_bmp[idx] = bmp;
        pool_vol[idx] = vol;
        pool_sid[idx] = sid;
        pool_tag[idx] = tag;
      end
      OP_POP_SECTOR: begin
        if (int'(idx) < n) begin
          if (claim_page(int'(idx), hit)) res = hit;
        end
      end
      OP_POP_ANY: begin
        if (n != 0) begin
          start = int'(rr_cursor) % n;
          for (int i = 0; i < n && !got; i++) got = claim_page((start + i) % n, hit);
          if (got) res = hit;
        end
        // cursor moves on whether or not a page was found
        rr_cursor = rr_cursor + 1'b1;
        if (!got && drained_flag && (worker_cnt == '0 || worker_cnt[WRK_W-1]))
          res.eow = 1'b1;
      end
      OP_QUERY: ;
      OP_ENTER:   worker_cnt = worker_cnt + 1'b1;
      OP_LEAVE:   worker_cnt = worker_cnt - 1'b1;
      OP_NO_MORE: drained_flag = 1'b1;
      default: begin
        rr_cursor    = '0;
        worker_cnt   = '0;
        drained_flag = 1'b0;
      end
    endcase
    for (int i = 0; i < n; i++) begin
      if (pool_bmp[i] != '0) res.left = 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_cnt++;
    $display("%0t checker: %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    page_result_t want;
    if (rst) begin
      for (int i = 0; i < MAX_SECTORS; i++) begin
        pool_bmp[i] = '0;
        pool_vol[i] = '0;
        pool_sid[i] = '0;
        pool_tag[i] = '0;
      end
      rr_cursor    = '0;
      worker_cnt   = '0;
      drained_flag = 1'b0;
      entry_limit  = CNT_W'(MAX_SECTORS);
      awaited_pages.delete();
    end else begin
      if (out_valid && !out_stall) begin
        res_cnt++;
        if (awaited_pages.size() == 0) begin
          report_mismatch("result with no transaction outstanding", 64'(page_id), 64'd0);
        end else begin
          want = awaited_pages.pop_front();
          check_field("found", 64'(found), 64'(want.found));
          check_field("slot_used", 64'(slot_used), 64'(want.slot));
          check_field("page_volume", 64'(page_volume), 64'(want.vol));
          check_field("page_id", 64'(page_id), 64'(want.pid));
          check_field("file_tag_out", 64'(file_tag_out), 64'(want.tag));
          check_field("pages_left", 64'(pages_left), 64'(want.left));
          check_field("end_of_work", 64'(end_of_work), 64'(want.eow));
          if (want.found) page_cnt++;
          if (want.eow) eow_cnt++;
        end
      end
      if (cfg_we) entry_limit = cfg_wdata;
      if (in_valid && !in_stall)
        awaited_pages.push_back(dispense_page(op_t'(opcode), sector_index, pending_bits,
                                              volume_id, sector_id, file_tag));
    end
    errors       <= err_cnt;
    pending      <= awaited_pages.size();
    results_seen <= res_cnt;
    pages_seen   <= page_cnt;
    eow_seen     <= eow_cnt;
  end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the bitmap page dispenser: a directed opening over
// the corner cases, then phases of random transactions under several sector
// counts, with bursty input and a patterned output stall.
// ----------------------------------------------------------------------------
module testbench import bpd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             cfg_we       = 1'b0;
  logic [CNT_W-1:0] cfg_wdata    = '0;
  logic             in_valid     = 1'b0;
  logic             in_stall;
  logic [2:0]       opcode       = OP_QUERY;
  logic [IDX_W-1:0] sector_index = '0;
  logic [BMP_W-1:0] pending_bits = '0;
  logic [VOL_W-1:0] volume_id    = '0;
  logic [SID_W-1:0] sector_id    = '0;
  logic [TAG_W-1:0] file_tag     = '0;
  logic             out_valid;
  logic             out_stall    = 1'b0;
  logic             found;
  logic [IDX_W-1:0] slot_used;
  logic [VOL_W-1:0] page_volume;
  logic [PID_W-1:0] page_id;
  logic [TAG_W-1:0] file_tag_out;
  logic             pages_left;
  logic             end_of_work;

  int errors;
  int pending;
  int results_seen;
  int pages_seen;
  int eow_seen;

  int burst_left    = 0;
  bit steady        = 1'b0;
  int live_entries  = MAX_SECTORS;
  int settings_used = 0;
  int stall_mode    = 0;
  int stall_run     = 0;

  bitmap_page_dispenser_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .sector_index (sector_index),
    .pending_bits (pending_bits),
    .volume_id    (volume_id),
    .sector_id    (sector_id),
    .file_tag     (file_tag),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .slot_used    (slot_used),
    .page_volume  (page_volume),
    .page_id      (page_id),
    .file_tag_out (file_tag_out),
    .pages_left   (pages_left),
    .end_of_work  (end_of_work)
  );

  bpd_scoreboard u_scoreboard (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .sector_index (sector_index),
    .pending_bits (pending_bits),
    .volume_id    (volume_id),
    .sector_id    (sector_id),
    .file_tag     (file_tag),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .slot_used    (slot_used),
    .page_volume  (page_volume),
    .page_id      (page_id),
    .file_tag_out (file_tag_out),
    .pages_left   (pages_left),
    .end_of_work  (end_of_work),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen),
    .pages_seen   (pages_seen),
    .eow_seen     (eow_seen)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  // receiver: runs of free flow, light stall, heavy stall and a fixed pattern
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run  <= $urandom_range(20, 200);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_run % 16) < 10);
    endcase
  end

  // one transaction; returns at the edge where it is accepted
  task automatic put_item(input op_t op, input logic [IDX_W-1:0] idx,
                          input logic [BMP_W-1:0] bmp, input logic [VOL_W-1:0] vol,
                          input logic [SID_W-1:0] sid, input logic [TAG_W-1:0] tag);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady) gap = $urandom_range(1, 8);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    sector_index <= idx;
    pending_bits <= bmp;
    volume_id    <= vol;
    sector_id    <= sid;
    file_tag     <= tag;
    burst_left--;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic put_op(input op_t op, input logic [IDX_W-1:0] idx);
    put_item(op, idx, '0, '0, '0, '0);
  endtask

  // wait for every outstanding result, then let the last commit land
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_sector_count(input logic [CNT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    live_entries = (int'(v) > MAX_SECTORS) ? MAX_SECTORS : int'(v);
    settings_used++;
  endtask

  function automatic logic [31:0] pick_value(input int w);
    logic [31:0] mask;
    mask = (32'h1 << w) - 1;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return mask;
      default: return $urandom & mask;
    endcase
  endfunction

  function automatic logic [BMP_W-1:0] pick_bitmap();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return 64'd1 << $urandom_range(0, 63);
      2, 3, 4: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      5:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_item();
    int r;
    op_t op;
    logic [IDX_W-1:0] idx;
    r = $urandom_range(0, 99);
    if (r < 16)      op = OP_LOAD;
    else if (r < 40) op = OP_POP_SECTOR;
    else if (r < 68) op = OP_POP_ANY;
    else if (r < 73) op = OP_QUERY;
    else if (r < 81) op = OP_ENTER;
    else if (r < 89) op = OP_LEAVE;
    else if (r < 95) op = OP_NO_MORE;
    else             op = OP_RESTART;
    // mostly entries in use, sometimes anywhere in the table
    if (live_entries > 0 && $urandom_range(0, 4) != 0)
      idx = IDX_W'($urandom_range(0, live_entries - 1));
    else
      idx = IDX_W'($urandom_range(0, 63));
    put_item(op, idx, pick_bitmap(), VOL_W'(pick_value(VOL_W)),
             SID_W'(pick_value(SID_W)), TAG_W'(pick_value(TAG_W)));
  endtask

  initial begin
    logic [CNT_W-1:0] counts [10];
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed opening, sector count at its reset value
    put_op(OP_QUERY, 6'd0);
    put_op(OP_POP_ANY, 6'd0);
    put_op(OP_POP_SECTOR, 6'd0);
    put_item(OP_LOAD, 6'd0, '1, '1, '1, '1);
    put_item(OP_LOAD, 6'd63, 64'd1 << 63, '0, '0, '0);
    put_item(OP_LOAD, 6'd5, '0, 15'h1234, 25'h0ABCDEF, 8'h5A);
    put_op(OP_POP_SECTOR, 6'd63);
    put_op(OP_POP_SECTOR, 6'd63);
    put_op(OP_POP_SECTOR, 6'd0);
    put_op(OP_POP_ANY, 6'd0);
    put_op(OP_ENTER, 6'd0);
    put_op(OP_NO_MORE, 6'd0);
    put_item(OP_LOAD, 6'd0, '0, '1, '1, '1);
    put_op(OP_POP_ANY, 6'd0);
    put_op(OP_LEAVE, 6'd0);
    put_op(OP_POP_ANY, 6'd0);
    put_op(OP_LEAVE, 6'd0);
    put_op(OP_POP_ANY, 6'd0);
    put_op(OP_RESTART, 6'd0);
    put_op(OP_POP_ANY, 6'd0);
    put_item(OP_LOAD, 6'd40, 64'hA5A5_0000_0000_8001, 15'h0001, 25'h1000000, 8'h80);
    put_op(OP_POP_ANY, 6'd0);

    counts[0] = 7'd1;
    counts[1] = 7'd64;
    counts[2] = 7'd0;
    counts[3] = 7'd127;
    counts[4] = 7'd2;
    counts[5] = 7'd5;
    counts[6] = CNT_W'($urandom_range(1, 12));
    counts[7] = CNT_W'($urandom_range(1, 127));
    counts[8] = CNT_W'($urandom_range(1, 12));
    counts[9] = 7'd64;

    for (int p = 0; p < 10; p++) begin
      settle();
      set_sector_count(counts[p]);
      steady = (p % 3 == 2);
      if (counts[p] == 0) begin
        // nothing in use: walk the worker count past its sign bit
        put_op(OP_RESTART, 6'd0);
        put_op(OP_NO_MORE, 6'd0);
        repeat (255) put_op(OP_ENTER, 6'd0);
        put_op(OP_POP_ANY, 6'd0);
        put_op(OP_ENTER, 6'd0);
        put_op(OP_POP_ANY, 6'd0);
        repeat (60) random_item();
      end else begin
        repeat (150) random_item();
      end
    end
    settle();
    repeat (20) @(posedge clk);

    $display("tb: %0d transactions checked over %0d sector-count settings,",
             results_seen, settings_used);
    $display("tb: %0d pages out, %0d end-of-work", pages_seen, eow_seen);
    if (pending != 0) $display("tb: %0d expected results never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/bpd_pkg.sv
hw/rtl/bpd_ram.sv
hw/rtl/bpd_ctrl.sv
hw/rtl/bpd_dp.sv
hw/rtl/bitmap_page_dispenser_unit.sv
hw/rtl/bpd_checker.sv
dv/bpd_checker.sv
dv/testbench.sv
